/* rtl/pngunf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared constants, filter and register codes, and the per-byte item record
// that travels from the sequencer to the reconstruction stage.
// ----------------------------------------------------------------------------
package pngunf_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_BPP         = 8;

  localparam int BYTE_W          = 8;
  localparam int BPP_REG_W       = 4;
  localparam int ROW_BYTES_REG_W = 14;
  localparam int ROW_COUNT_W     = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 2;

  localparam int COL_W     = $clog2(MAX_ROW_BYTES);
  localparam int BPP_IDX_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int CMP_W     = (COL_W > BPP_REG_W) ? COL_W : BPP_REG_W;
  localparam int RB_CMP_W  = ((COL_W > ROW_BYTES_REG_W) ? COL_W : ROW_BYTES_REG_W) + 1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  localparam logic [BYTE_W-1:0] FILT_MAX_CODE = BYTE_W'(FILT_PAETH);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BPP       = 2'd0,
    REG_ROW_BYTES = 2'd1,
    REG_ROW_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    filter_t              filter;
    logic                 bad;
    logic                 have_left;
    logic                 have_up;
    logic                 end_row;
    logic                 end_img;
    logic [BPP_IDX_W-1:0] bpp_sel;
    logic [COL_W-1:0]     col;
  } item_t;

endpackage

/* rtl/pngunf_row_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prior row memory
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered and held while no read is issued.
// ----------------------------------------------------------------------------
module pngunf_row_mem #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/pngunf_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG unfilter sequencer
// Holds the configuration, decodes the filter-type byte of each row, tracks
// column and row position, issues the prior-row read and loads the stage
// register that feeds reconstruction.
// ----------------------------------------------------------------------------
module pngunf_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pngunf_pkg::BYTE_W-1:0]        stream_byte,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pngunf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pngunf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                 advance,
  output logic                                 s1_valid,
  output pngunf_pkg::item_t                    s1_item,
  output logic [pngunf_pkg::BYTE_W-1:0]        s1_byte,
  output logic                                 rd_en,
  output logic [pngunf_pkg::COL_W-1:0]         rd_addr
);

  logic [pngunf_pkg::BPP_REG_W-1:0]       bytes_per_pixel;
  logic [pngunf_pkg::ROW_BYTES_REG_W-1:0] row_bytes;
  logic [pngunf_pkg::ROW_COUNT_W-1:0]     row_count;

  logic                               awaiting_type;
  logic [pngunf_pkg::COL_W-1:0]       column_pos;
  logic [pngunf_pkg::ROW_COUNT_W-1:0] row_pos;
  pngunf_pkg::filter_t                row_filter;
  logic                               row_bad;

  logic [pngunf_pkg::BPP_REG_W-1:0]       bpp_eff;
  logic [pngunf_pkg::ROW_BYTES_REG_W-1:0] rb_eff;
  logic [pngunf_pkg::ROW_COUNT_W-1:0]     rc_eff;
  logic [pngunf_pkg::BPP_REG_W-1:0]       bpp_less1;
  logic [pngunf_pkg::RB_CMP_W-1:0]        col_plus1;
  logic [pngunf_pkg::ROW_COUNT_W:0]       row_plus1;
  logic                                   accept;
  logic                                   take_data;
  logic                                   end_row;
  logic                                   end_img;
  pngunf_pkg::item_t                      item_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= pngunf_pkg::BPP_REG_W'(1);
      row_bytes       <= pngunf_pkg::ROW_BYTES_REG_W'(1);
      row_count       <= pngunf_pkg::ROW_COUNT_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pngunf_pkg::REG_BPP: begin
          bytes_per_pixel <= cfg_data[pngunf_pkg::BPP_REG_W-1:0];
        end
        pngunf_pkg::REG_ROW_BYTES: begin
          row_bytes <= cfg_data[pngunf_pkg::ROW_BYTES_REG_W-1:0];
        end
        pngunf_pkg::REG_ROW_COUNT: begin
          row_count <= cfg_data[pngunf_pkg::ROW_COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings are clamped into the legal range.
  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = pngunf_pkg::BPP_REG_W'(1);
    end else if (bytes_per_pixel > pngunf_pkg::BPP_REG_W'(pngunf_pkg::MAX_BPP)) begin
      bpp_eff = pngunf_pkg::BPP_REG_W'(pngunf_pkg::MAX_BPP);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
    if (row_bytes == '0) begin
      rb_eff = pngunf_pkg::ROW_BYTES_REG_W'(1);
    end else if (pngunf_pkg::RB_CMP_W'(row_bytes) >
                 pngunf_pkg::RB_CMP_W'(pngunf_pkg::MAX_ROW_BYTES)) begin
      rb_eff = pngunf_pkg::ROW_BYTES_REG_W'(pngunf_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = row_bytes;
    end
    rc_eff = (row_count == '0) ? pngunf_pkg::ROW_COUNT_W'(1) : row_count;
  end

  assign bpp_less1 = bpp_eff - pngunf_pkg::BPP_REG_W'(1);
  assign col_plus1 = pngunf_pkg::RB_CMP_W'(column_pos) + pngunf_pkg::RB_CMP_W'(1);
  assign row_plus1 = {1'b0, row_pos} + (pngunf_pkg::ROW_COUNT_W + 1)'(1);
  assign end_row   = col_plus1 >= pngunf_pkg::RB_CMP_W'(rb_eff);
  assign end_img   = end_row && (row_plus1 >= {1'b0, rc_eff});

  // A new word may enter whenever the stage register is empty or moving on.
  assign in_stall  = s1_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign take_data = accept && !awaiting_type;

  assign rd_en   = take_data;
  assign rd_addr = column_pos;

  always_comb begin
    item_next.filter    = row_filter;
    item_next.bad       = row_bad;
    item_next.have_left = pngunf_pkg::CMP_W'(column_pos) >= pngunf_pkg::CMP_W'(bpp_eff);
    item_next.have_up   = row_pos != '0;
    item_next.end_row   = end_row;
    item_next.end_img   = end_img;
    item_next.bpp_sel   = bpp_less1[pngunf_pkg::BPP_IDX_W-1:0];
    item_next.col       = column_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_type <= 1'b1;
      column_pos    <= '0;
      row_pos       <= '0;
      row_filter    <= pngunf_pkg::FILT_NONE;
      row_bad       <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      if (take_data) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (accept) begin
        if (awaiting_type) begin
          awaiting_type <= 1'b0;
          column_pos    <= '0;
          if (stream_byte > pngunf_pkg::FILT_MAX_CODE) begin
            row_bad    <= 1'b1;
            row_filter <= pngunf_pkg::FILT_NONE;
          end else begin
            row_bad    <= 1'b0;
            row_filter <= pngunf_pkg::filter_t'(stream_byte[2:0]);
          end
        end else if (end_row) begin
          column_pos    <= '0;
          awaiting_type <= 1'b1;
          row_pos       <= end_img ? '0 : row_plus1[pngunf_pkg::ROW_COUNT_W-1:0];
        end else begin
          column_pos <= column_pos + pngunf_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_data) begin
      s1_item <= item_next;
      s1_byte <= stream_byte;
    end
  end

endmodule

/* rtl/pngunf_recon.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG unfilter reconstruction stage
// Forms left, up and up-left, applies the row's filter, writes the result
// back to the prior row memory and holds it in the output register.
// ----------------------------------------------------------------------------
module pngunf_recon (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  input  pngunf_pkg::item_t             s1_item,
  input  logic [pngunf_pkg::BYTE_W-1:0] s1_byte,
  input  logic [pngunf_pkg::BYTE_W-1:0] up_raw,
  output logic                          advance,
  output logic                          wr_en,
  output logic [pngunf_pkg::COL_W-1:0]  wr_addr,
  output logic [pngunf_pkg::BYTE_W-1:0] wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pngunf_pkg::BYTE_W-1:0] pixel_byte,
  output logic                          last_in_row,
  output logic                          last_in_image,
  output logic                          bad_filter
);

  // Paeth predictor with the distances rewritten as |b-c|, |a-c|, |a+b-2c|.
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0]         pa;
    logic [9:0]         pb;
    logic [9:0]         pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[10] ? 10'(-da) : 10'(da);
    pb = db[10] ? 10'(-db) : 10'(db);
    pc = dc[10] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

  logic [pngunf_pkg::BYTE_W-1:0] left_bytes   [pngunf_pkg::MAX_BPP];
  logic [pngunf_pkg::BYTE_W-1:0] upleft_bytes [pngunf_pkg::MAX_BPP];

  logic [pngunf_pkg::BYTE_W-1:0] left;
  logic [pngunf_pkg::BYTE_W-1:0] up;
  logic [pngunf_pkg::BYTE_W-1:0] upleft;
  logic [pngunf_pkg::BYTE_W:0]   sum_lu;
  logic [pngunf_pkg::BYTE_W-1:0] pred;
  logic [pngunf_pkg::BYTE_W-1:0] val;

  assign advance = s1_valid && (!out_valid || !out_stall);

  assign left   = s1_item.have_left ? left_bytes[s1_item.bpp_sel] : '0;
  assign up     = s1_item.have_up ? up_raw : '0;
  assign upleft = (s1_item.have_left && s1_item.have_up) ? upleft_bytes[s1_item.bpp_sel] : '0;
  assign sum_lu = {1'b0, left} + {1'b0, up};

  always_comb begin
    case (s1_item.filter)
      pngunf_pkg::FILT_SUB:   pred = left;
      pngunf_pkg::FILT_UP:    pred = up;
      pngunf_pkg::FILT_AVG:   pred = sum_lu[pngunf_pkg::BYTE_W:1];
      pngunf_pkg::FILT_PAETH: pred = paeth(left, up, upleft);
      default:                pred = '0;
    endcase
  end

  assign val = s1_byte + pred;

  assign wr_en   = advance;
  assign wr_addr = s1_item.col;
  assign wr_data = val;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_byte      <= val;
      last_in_row     <= s1_item.end_row;
      last_in_image   <= s1_item.end_img;
      bad_filter      <= s1_item.bad;
      left_bytes[0]   <= val;
      upleft_bytes[0] <= up;
      for (int i = 1; i < pngunf_pkg::MAX_BPP; i++) begin
        left_bytes[i]   <= left_bytes[i-1];
        upleft_bytes[i] <= upleft_bytes[i-1];
      end
    end
  end

endmodule

/* rtl/png_scanline_unfilter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds raw image bytes from the filtered scanline stream (none, sub, up,
// average and Paeth filters), keeping the previous row in a RAM.
//
//   channel   handshake                 payload
//   input     in_valid / in_stall       stream_byte
//   output    out_valid / out_stall     pixel_byte, last_in_row,
//                                       last_in_image, bad_filter
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word is accepted per cycle while the input is not stalled; a data byte's
// accepting edge issues the prior-row RAM read and loads the filter stage, and
// the edge on which the stage moves on writes the result back and loads the
// output register. Filter-type bytes give no output.
// Reset is synchronous and clears all control state; no clearing pass runs.
// A stall on the output fills the filter stage, then stalls the input.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pngunf_pkg::BYTE_W-1:0]       stream_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pngunf_pkg::BYTE_W-1:0]       pixel_byte,
  output logic                                last_in_row,
  output logic                                last_in_image,
  output logic                                bad_filter,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pngunf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pngunf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                          advance;
  logic                          s1_valid;
  pngunf_pkg::item_t             s1_item;
  logic [pngunf_pkg::BYTE_W-1:0] s1_byte;
  logic                          rd_en;
  logic [pngunf_pkg::COL_W-1:0]  rd_addr;
  logic [pngunf_pkg::BYTE_W-1:0] rd_data;
  logic                          wr_en;
  logic [pngunf_pkg::COL_W-1:0]  wr_addr;
  logic [pngunf_pkg::BYTE_W-1:0] wr_data;

  pngunf_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_byte (stream_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .advance     (advance),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item),
    .s1_byte     (s1_byte),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  pngunf_row_mem #(
    .DEPTH (pngunf_pkg::MAX_ROW_BYTES),
    .WIDTH (pngunf_pkg::BYTE_W)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pngunf_recon u_recon (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item),
    .s1_byte       (s1_byte),
    .up_raw        (rd_data),
    .advance       (advance),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_byte    (pixel_byte),
    .last_in_row   (last_in_row),
    .last_in_image (last_in_image),
    .bad_filter    (bad_filter)
  );

  // The read of the next column never meets the write-back of the current one.
  assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("prior row read and write hit the same entry");

  // The input only stalls while the filter stage holds a word that cannot move.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && !advance))
    else $error("input stalled with a free filter stage");

  // A word leaving the filter stage is presented at the output next cycle.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("filtered word lost on the way to the output register");

  // The end of the image is always the end of a row.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_in_image) |-> last_in_row)
    else $error("image end flagged without row end");

endmodule
